/* sv/fpsa_pkg.sv */
// shared constants, types and helpers of the free page stack allocator
`default_nettype none
package fpsa_pkg;

   localparam int STACK_DEPTH = 4096;
   localparam int PAGE_BYTES  = 4096;
   localparam int ADDR_W      = 48;

   localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int NP_W        = $clog2(STACK_DEPTH + 2);

   localparam int OP_W        = 2;
   localparam int RTYPE_W     = 2;
   localparam int STATUS_W    = 2;
   localparam int FIELD_CNT_W = 13;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [OP_W-1:0]    OP_REGION   = 2'd0;
   localparam logic [OP_W-1:0]    OP_ALLOC    = 2'd1;
   localparam logic [OP_W-1:0]    OP_FREE     = 2'd2;
   localparam logic [RTYPE_W-1:0] RTYPE_USABLE = 2'd0;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [1:0] {
      KIND_NOP    = 2'd0,
      KIND_REGION = 2'd1,
      KIND_ALLOC  = 2'd2,
      KIND_FREE   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [ADDR_W-1:0]   address;
      logic [NP_W-1:0]     npages;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qhead_type;

   function automatic logic [FIELD_CNT_W-1:0] to_field(input logic [CNT_W-1:0] v);
      logic [CNT_W+FIELD_CNT_W-1:0] wide;
      wide = {{FIELD_CNT_W{1'b0}}, v};
      return wide[FIELD_CNT_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* sv/fpsa_if.sv */
// request and response channel interfaces
`default_nettype none
interface fpsa_req_if;
   logic                                valid;
   logic                                ready;
   logic [fpsa_pkg::OP_W-1:0]           op;
   logic [fpsa_pkg::ADDR_W-1:0]         address;
   logic [fpsa_pkg::ADDR_W-1:0]         region_size;
   logic [fpsa_pkg::RTYPE_W-1:0]        region_type;
   modport source (output valid, output op, output address, output region_size,
                   output region_type, input ready);
   modport sink   (input valid, input op, input address, input region_size,
                   input region_type, output ready);
endinterface

interface fpsa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [fpsa_pkg::STATUS_W-1:0]       status;
   logic [fpsa_pkg::ADDR_W-1:0]         page_address;
   logic [fpsa_pkg::FIELD_CNT_W-1:0]    pages_added;
   logic [fpsa_pkg::FIELD_CNT_W-1:0]    free_pages;
   modport source (output valid, output status, output page_address,
                   output pages_added, output free_pages, input ready);
   modport sink   (input valid, input status, input page_address,
                   input pages_added, input free_pages, output ready);
endinterface
`default_nettype wire

/* sv/fpsa_ram.sv */
// generic single write, single registered read ram
`default_nettype none
module fpsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

/* sv/fpsa_front.sv */
// request intake, classification and command queue
`default_nettype none
module fpsa_front (
   input  wire logic                clock,
   input  wire logic                reset,
   fpsa_req_if.sink                 req_chan,
   output fpsa_pkg::qhead_type      head,
   input  wire logic                pop
);
   fpsa_pkg::cmd_type                 entry_ff [fpsa_pkg::QUEUE_DEPTH];
   logic [fpsa_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [fpsa_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [fpsa_pkg::QFILL_W-1:0]      fill_ff, fill_in;
   fpsa_pkg::cmd_type                 cmd;
   logic [fpsa_pkg::ADDR_W-1:0]       pages_raw;
   logic                              push;
   logic                              do_pop;

   // classify the transaction
   always_comb begin
      pages_raw   = req_chan.region_size >> fpsa_pkg::PAGE_SHIFT;
      cmd.address = req_chan.address;
      if (pages_raw > fpsa_pkg::ADDR_W'(fpsa_pkg::STACK_DEPTH)) begin
         cmd.npages = fpsa_pkg::NP_W'(fpsa_pkg::STACK_DEPTH + 1);
      end else begin
         cmd.npages = pages_raw[fpsa_pkg::NP_W-1:0];
      end
      case (req_chan.op)
         fpsa_pkg::OP_REGION: begin
            cmd.kind = (req_chan.region_type == fpsa_pkg::RTYPE_USABLE)
                       ? fpsa_pkg::KIND_REGION : fpsa_pkg::KIND_NOP;
         end
         fpsa_pkg::OP_ALLOC: cmd.kind = fpsa_pkg::KIND_ALLOC;
         fpsa_pkg::OP_FREE:  cmd.kind = fpsa_pkg::KIND_FREE;
         default:            cmd.kind = fpsa_pkg::KIND_NOP;
      endcase
   end

   assign req_chan.ready = (fill_ff != fpsa_pkg::QFILL_W'(fpsa_pkg::QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign do_pop         = pop && (fill_ff != '0);

   assign head.valid = (fill_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == fpsa_pkg::QPTR_W'(fpsa_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == fpsa_pkg::QPTR_W'(fpsa_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && do_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd;
      end
   end
endmodule
`default_nettype wire

/* sv/fpsa_back.sv */
// stack execution engine with response register
`default_nettype none
module fpsa_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire fpsa_pkg::qhead_type head,
   output logic                     pop,
   fpsa_rsp_if.source               rsp_chan
);
   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_CARVE = 3'b010,
      S_READ  = 3'b100
   } state_type;

   state_type                         state_ff, state_in;
   logic [fpsa_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [fpsa_pkg::CNT_W-1:0]        remain_ff, remain_in;
   logic [fpsa_pkg::CNT_W-1:0]        added_ff, added_in;
   logic [fpsa_pkg::ADDR_W-1:0]       addr_ff, addr_in;
   logic                              full_ff, full_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [fpsa_pkg::STATUS_W-1:0]     status_ff;
   logic [fpsa_pkg::ADDR_W-1:0]       page_ff;
   logic [fpsa_pkg::FIELD_CNT_W-1:0]  pages_added_ff, free_pages_ff;

   logic                              out_free;
   logic [fpsa_pkg::CNT_W-1:0]        room;
   logic                              overflow;
   logic [fpsa_pkg::CNT_W-1:0]        take;
   logic                              set_rsp;
   logic [fpsa_pkg::STATUS_W-1:0]     set_status;
   logic [fpsa_pkg::ADDR_W-1:0]       set_page;
   logic [fpsa_pkg::CNT_W-1:0]        set_added, set_free;
   logic                              wr_en, rd_en;
   logic [fpsa_pkg::ADDR_W-1:0]       wr_data, rd_data;
   logic [fpsa_pkg::CNT_W-1:0]        rd_count;

   fpsa_ram #(
      .WIDTH (fpsa_pkg::ADDR_W),
      .DEPTH (fpsa_pkg::STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[fpsa_pkg::IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_count[fpsa_pkg::IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign room     = fpsa_pkg::CNT_W'(fpsa_pkg::STACK_DEPTH) - count_ff;
   assign overflow = head.cmd.npages > fpsa_pkg::NP_W'(room);
   assign take     = overflow ? room : fpsa_pkg::CNT_W'(head.cmd.npages);
   assign rd_count = count_ff - 1'b1;
   assign wr_data  = (state_ff == S_CARVE) ? addr_ff : head.cmd.address;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      added_in     = added_ff;
      addr_in      = addr_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      pop          = 1'b0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      set_rsp      = 1'b0;
      set_status   = fpsa_pkg::STATUS_OK;
      set_page     = '0;
      set_added    = '0;
      set_free     = count_ff;
      case (state_ff)
         S_IDLE: begin
            if (head.valid && out_free) begin
               pop = 1'b1;
               case (head.cmd.kind)
                  fpsa_pkg::KIND_REGION: begin
                     if (take == '0) begin
                        set_rsp    = 1'b1;
                        set_status = overflow ? fpsa_pkg::STATUS_FULL : fpsa_pkg::STATUS_OK;
                     end else begin
                        state_in  = S_CARVE;
                        addr_in   = head.cmd.address;
                        remain_in = take;
                        added_in  = take;
                        full_in   = overflow;
                     end
                  end
                  fpsa_pkg::KIND_ALLOC: begin
                     if (count_ff == '0) begin
                        set_rsp    = 1'b1;
                        set_status = fpsa_pkg::STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        count_in = rd_count;
                        state_in = S_READ;
                     end
                  end
                  fpsa_pkg::KIND_FREE: begin
                     set_rsp = 1'b1;
                     if (count_ff == fpsa_pkg::CNT_W'(fpsa_pkg::STACK_DEPTH)) begin
                        set_status = fpsa_pkg::STATUS_FULL;
                     end else begin
                        wr_en     = 1'b1;
                        count_in  = count_ff + 1'b1;
                        set_added = fpsa_pkg::CNT_W'(1);
                        set_free  = count_ff + 1'b1;
                     end
                  end
                  default: begin
                     set_rsp = 1'b1;
                  end
               endcase
            end
         end
         S_CARVE: begin
            wr_en     = 1'b1;
            count_in  = count_ff + 1'b1;
            addr_in   = addr_ff + fpsa_pkg::ADDR_W'(fpsa_pkg::PAGE_BYTES);
            remain_in = remain_ff - 1'b1;
            if (remain_ff == fpsa_pkg::CNT_W'(1)) begin
               state_in   = S_IDLE;
               set_rsp    = 1'b1;
               set_status = full_ff ? fpsa_pkg::STATUS_FULL : fpsa_pkg::STATUS_OK;
               set_added  = added_ff;
               set_free   = count_ff + 1'b1;
            end
         end
         S_READ: begin
            state_in = S_IDLE;
            set_rsp  = 1'b1;
            set_page = rd_data;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (set_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      added_ff <= added_in;
      addr_ff  <= addr_in;
      full_ff  <= full_in;
      if (set_rsp) begin
         status_ff      <= set_status;
         page_ff        <= set_page;
         pages_added_ff <= fpsa_pkg::to_field(set_added);
         free_pages_ff  <= fpsa_pkg::to_field(set_free);
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.page_address = page_ff;
   assign rsp_chan.pages_added  = pages_added_ff;
   assign rsp_chan.free_pages   = free_pages_ff;
endmodule
`default_nettype wire

/* sv/free_page_stack_allocator.sv */
// top level of the free page stack allocator
// Free pages are kept as a last-in-first-out stack of page addresses in a
// single ram of STACK_DEPTH entries. Each request transaction enters a
// two-entry command queue and gets exactly one response transaction, held
// in an output register so the next request is taken while it waits. The
// execution engine takes one command once the output register is free:
// a free and any other item are answered from the idle state, an allocate
// goes on to a read state (registered ram read), and a usable region to a
// carve state in which the ram's single write port pushes one page per
// cycle (no carve state when no page is pushed). The stack needs no
// clearing after reset, so requests are taken right away.
`default_nettype none
module free_page_stack_allocator (
   input  wire logic   clock,
   input  wire logic   reset,
   fpsa_req_if.sink    req_chan,
   fpsa_rsp_if.source  rsp_chan
);
   fpsa_pkg::qhead_type head;
   logic                pop;

   fpsa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .head     (head),
      .pop      (pop)
   );

   fpsa_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );
endmodule
`default_nettype wire

/* sim/free_page_stack_allocator_checker.sv */
// scoreboard that predicts and checks every response transaction of the page allocator
`timescale 1ns / 100ps
module free_page_stack_allocator_checker
   import fpsa_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   fpsa_req_if         req_mon,
   fpsa_rsp_if         rsp_mon,
   output int unsigned fail_count,
   output int unsigned outstanding
);

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [ADDR_W-1:0]      page_address;
      logic [FIELD_CNT_W-1:0] pages_added;
      logic [FIELD_CNT_W-1:0] free_pages;
   } page_grant_t;

   logic [ADDR_W-1:0] free_list [STACK_DEPTH];
   int unsigned       held_pages = 0;
   page_grant_t       expected_grants [$];
   int unsigned       errors = 0;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   function automatic page_grant_t apply_request(input logic [OP_W-1:0]    op,
                                                 input logic [ADDR_W-1:0]  address,
                                                 input logic [ADDR_W-1:0]  region_size,
                                                 input logic [RTYPE_W-1:0] region_type);
      page_grant_t     grant;
      longint unsigned wanted;
      longint unsigned taken;
      longint unsigned k;
      grant = '0;
      case (op)
         OP_REGION: begin
            if (region_type == RTYPE_USABLE) begin
               wanted = 64'(region_size) / 64'(PAGE_BYTES);
               taken  = STACK_DEPTH - held_pages;
               if (wanted < taken) begin
                  taken = wanted;
               end
               for (k = 0; k < taken; k++) begin
                  free_list[held_pages] = address + ADDR_W'(k * PAGE_BYTES);
                  held_pages++;
               end
               grant.pages_added = FIELD_CNT_W'(taken);
               if (wanted > taken) begin
                  grant.status = STATUS_FULL;
               end
            end
         end
         OP_ALLOC: begin
            if (held_pages == 0) begin
               grant.status = STATUS_EMPTY;
            end else begin
               held_pages--;
               grant.page_address = free_list[held_pages];
            end
         end
         OP_FREE: begin
            if (held_pages < STACK_DEPTH) begin
               free_list[held_pages] = address;
               held_pages++;
               grant.pages_added = 1;
            end else begin
               grant.status = STATUS_FULL;
            end
         end
         default: ;
      endcase
      grant.free_pages = FIELD_CNT_W'(held_pages);
      return grant;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] expected,
                                       input logic [63:0] actual);
      if (actual !== expected) begin
         $error("%s expected 0x%0h got 0x%0h", name, expected, actual);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : scoreboard
      page_grant_t oldest;
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_grants.size() == 0) begin
               $error("response transaction with no request outstanding");
               errors++;
            end else begin
               oldest = expected_grants.pop_front();
               check_field("status", oldest.status, rsp_mon.status);
               check_field("page_address", oldest.page_address, rsp_mon.page_address);
               check_field("pages_added", oldest.pages_added, rsp_mon.pages_added);
               check_field("free_pages", oldest.free_pages, rsp_mon.free_pages);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_grants.push_back(apply_request(req_mon.op, req_mon.address,
                                                    req_mon.region_size,
                                                    req_mon.region_type));
         end
      end
      fail_count  <= errors;
      outstanding <= expected_grants.size();
   end

endmodule

/* sim/free_page_stack_allocator_tb.sv */
// top of the page allocator testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module free_page_stack_allocator_tb;
   import fpsa_pkg::*;

   localparam logic [OP_W-1:0]    OP_RESERVED    = 2'd3;
   localparam logic [RTYPE_W-1:0] RTYPE_UNUSABLE = 2'd1;
   localparam logic [RTYPE_W-1:0] RTYPE_MMIO     = 2'd2;
   localparam logic [RTYPE_W-1:0] RTYPE_KERNEL   = 2'd3;
   localparam logic [ADDR_W-1:0]  ADDR_ALL_ONES  = '1;
   localparam int RANDOM_ITEMS   = 1450;
   localparam int DRAIN_LIMIT    = 1200;
   localparam int SETTLE_CYCLES  = 32;
   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock;
   logic        reset;
   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned idle_cycles = 0;
   int unsigned empty_grants = 0;
   bit          calm = 1'b0;

   fpsa_req_if req_bus ();
   fpsa_rsp_if rsp_bus ();

   free_page_stack_allocator u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   free_page_stack_allocator_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (calm || roll < 60) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [ADDR_W-1:0] rand_addr();
      return ADDR_W'({$urandom(), $urandom()});
   endfunction

   function automatic logic [ADDR_W-1:0] rand_page();
      return rand_addr() & ~ADDR_W'(PAGE_BYTES - 1);
   endfunction

   task automatic send_request(input logic [OP_W-1:0]    op,
                               input logic [ADDR_W-1:0]  address,
                               input logic [ADDR_W-1:0]  region_size,
                               input logic [RTYPE_W-1:0] region_type);
      int unsigned gap;
      req_bus.valid       <= 1'b1;
      req_bus.op          <= op;
      req_bus.address     <= address;
      req_bus.region_size <= region_size;
      req_bus.region_type <= region_type;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      gap = pick_gap();
      if (gap != 0) begin
         req_bus.valid   <= 1'b0;
         req_bus.op      <= OP_W'($urandom);
         req_bus.address <= rand_addr();
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random_request();
      int unsigned       roll;
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] span;
      roll = $urandom_range(999);
      base = ($urandom_range(3) == 0) ? rand_addr() : rand_page();
      span = ADDR_W'($urandom_range(3) * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1));
      if (roll < 150)
         send_request(OP_REGION, base, span, RTYPE_USABLE);
      else if (roll < 155)
         send_request(OP_REGION, base, ADDR_W'($urandom_range(16, 96) * PAGE_BYTES),
                      RTYPE_USABLE);
      else if (roll < 355)
         send_request(OP_FREE, base, rand_addr(), RTYPE_W'($urandom));
      else if (roll < 805)
         send_request(OP_ALLOC, rand_addr(), rand_addr(), RTYPE_W'($urandom));
      else if (roll < 925)
         send_request(OP_REGION, rand_addr(), rand_addr(),
                      RTYPE_W'($urandom_range(RTYPE_UNUSABLE, RTYPE_KERNEL)));
      else
         send_request(OP_RESERVED, rand_addr(), rand_addr(), RTYPE_W'($urandom));
   endtask

   task automatic wait_all_answered();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin : response_sink
      int unsigned open_len;
      int unsigned stall_len;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      forever begin
         open_len  = ($urandom_range(7) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 10);
         stall_len = pick_gap();
         rsp_bus.ready <= 1'b1;
         repeat (open_len) @(posedge clock);
         if (stall_len != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready && rsp_bus.status == STATUS_EMPTY) begin
         empty_grants <= empty_grants + 1;
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned i;
      int unsigned empties_before;
      int unsigned drain_tries;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.op          = OP_ALLOC;
      req_bus.address     = '0;
      req_bus.region_size = '0;
      req_bus.region_type = RTYPE_USABLE;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners: empty stack, ignored items, tiny regions, address wrap, odd frees
      send_request(OP_ALLOC, '0, '0, RTYPE_USABLE);
      send_request(OP_RESERVED, ADDR_ALL_ONES, ADDR_ALL_ONES, RTYPE_KERNEL);
      send_request(OP_REGION, '0, ADDR_ALL_ONES, RTYPE_UNUSABLE);
      send_request(OP_REGION, ADDR_ALL_ONES, ADDR_ALL_ONES, RTYPE_MMIO);
      send_request(OP_REGION, 48'h1000, ADDR_ALL_ONES, RTYPE_KERNEL);
      send_request(OP_REGION, 48'h8000, '0, RTYPE_USABLE);
      send_request(OP_REGION, 48'h8000, ADDR_W'(PAGE_BYTES - 1), RTYPE_USABLE);
      send_request(OP_REGION, '0, ADDR_W'(PAGE_BYTES), RTYPE_USABLE);
      send_request(OP_REGION, ADDR_ALL_ONES, ADDR_W'(2 * PAGE_BYTES + 7), RTYPE_USABLE);
      send_request(OP_REGION, 48'hFFFF_FFFF_E000, ADDR_W'(3 * PAGE_BYTES), RTYPE_USABLE);
      send_request(OP_FREE, ADDR_ALL_ONES, '0, RTYPE_USABLE);
      send_request(OP_FREE, '0, ADDR_ALL_ONES, RTYPE_USABLE);
      send_request(OP_FREE, 48'h5555_AAAA_0F0F, '0, RTYPE_MMIO);
      repeat (10) send_request(OP_ALLOC, rand_addr(), rand_addr(), RTYPE_W'($urandom));

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         calm = (i % 200) >= 160;
         send_random_request();
      end
      calm = 1'b0;

      // empty the stack so the fill below pushes the whole depth
      wait_all_answered();
      empties_before = empty_grants;
      drain_tries    = 0;
      while (empty_grants == empties_before && drain_tries < DRAIN_LIMIT) begin
         send_request(OP_ALLOC, rand_addr(), rand_addr(), RTYPE_W'($urandom));
         drain_tries++;
      end

      send_request(OP_REGION, rand_page(), ADDR_ALL_ONES, RTYPE_USABLE);
      send_request(OP_FREE, rand_addr(), rand_addr(), RTYPE_W'($urandom));
      send_request(OP_REGION, rand_page(), ADDR_W'(PAGE_BYTES), RTYPE_USABLE);
      send_request(OP_ALLOC, rand_addr(), rand_addr(), RTYPE_W'($urandom));
      send_request(OP_FREE, rand_addr(), rand_addr(), RTYPE_W'($urandom));
      send_request(OP_RESERVED, rand_addr(), rand_addr(), RTYPE_W'($urandom));
      repeat (3) send_request(OP_ALLOC, rand_addr(), rand_addr(), RTYPE_W'($urandom));

      wait_all_answered();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* free_page_stack_allocator.f */
sv/fpsa_pkg.sv
sv/fpsa_if.sv
sv/fpsa_ram.sv
sv/fpsa_front.sv
sv/fpsa_back.sv
sv/free_page_stack_allocator.sv
sim/free_page_stack_allocator_checker.sv
sim/free_page_stack_allocator_tb.sv
